@@ design/ilff_pkg.sv @@
// Package for the first-fit heap allocator: payload structs, sequencer states, constants.
// No dependencies.
`timescale 1ns / 1ps
package ilff_pkg;
	localparam int HeapWords = 4096;
	localparam int AddrW = 12;
	localparam int TopW = 13;
	localparam int TagW = 16;
	localparam logic [TagW-1:0] TagEnd = 16'h0007;
	localparam logic [15:0] FreedMax = 16'hFFFF;

	localparam logic ActAlloc = 1'b0;
	localparam logic ActFree = 1'b1;

	localparam logic [1:0] StDone = 2'd0;
	localparam logic [1:0] StIgnored = 2'd1;
	localparam logic [1:0] StNoHeap = 2'd2;

	typedef struct packed {
		logic action;
		logic [14:0] request_bytes;
		logic [11:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [11:0] result_address;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FREE_RD,
		S_FREE_WAIT,
		S_FREE_WR,
		S_FIT_RD,
		S_FIT_WAIT,
		S_FIT_CHK,
		S_MRG_RD,
		S_MRG_WAIT,
		S_MRG_CHK,
		S_MRG_NRD,
		S_MRG_NWAIT,
		S_MRG_NCHK,
		S_MRG_WR1,
		S_MRG_WR2,
		S_PL_WR1,
		S_PL_WR2,
		S_PL_WR3,
		S_PL_WR4,
		S_EXT_WR1,
		S_EXT_WR2,
		S_EXT_WR3,
		S_OUT
	} seq_state_t;
endpackage

@@ design/implicit_list_first_fit_allocator_unit.sv @@
// Top level of the first-fit heap allocator: sequencer, shared adder, tag memory.
// Depends on ilff_pkg and ilff_tag_ram.
`timescale 1ns / 1ps
// One transaction at a time: the input stalls from acceptance until the result has been
// taken, and the block is ready again in the cycle after that. A null or out-of-range free
// and a zero-size allocate present their result in the cycle after acceptance. A free
// reads the header tag, clears its allocated bit and rewrites the footer before presenting
// its result. An allocate walks the block chain through the single read port of the tag
// memory, visiting each block in FIT_RD, FIT_WAIT and FIT_CHK. When nothing fits, a second
// walk follows, preceded by a merge pass when the freed total covers the request. The merge
// pass reads each block and each free neighbour absorbed, and makes two tag writes per
// merged run. The walk ends in up to four tag writes when placing, or three when extending
// the heap top. The total grows with the number of blocks. Word 0 holds the end marker
// from reset, written in the cycle after reset is released.
module implicit_list_first_fit_allocator_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ilff_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ilff_pkg::out_item_t out_data
);
	import ilff_pkg::*;

	seq_state_t state_q, state_d;
	logic init_q;
	logic [TopW-1:0] top_q, top_d;
	logic [15:0] freed_q, freed_d;
	logic [TopW-1:0] need_q, need_d;
	logic [TopW-1:0] h_q, h_d;
	logic [TopW-1:0] n_q, n_d;
	logic [TopW-1:0] size_q, size_d;
	logic [TopW-1:0] tot_q, tot_d;
	logic second_q, second_d;
	logic [AddrW-1:0] addr_q, addr_d;
	out_item_t res_q, res_d;

	logic we;
	logic [TopW-1:0] waddr;
	logic [TagW-1:0] wdata;
	logic [TopW-1:0] raddr;
	logic [TagW-1:0] rdata;

	// shared adder
	logic [TopW:0] add_a, add_b, add_y;
	assign add_y = add_a + add_b;

	ilff_tag_ram u_ram (
		.clk(clk),
		.we(we && (waddr < TopW'(HeapWords))),
		.waddr(waddr[AddrW-1:0]),
		.wdata(wdata),
		.raddr(raddr[AddrW-1:0]),
		.rdata(rdata)
	);

	// walk size of the tag just read at index idx
	function automatic logic [TopW-1:0] wsize(logic [TopW-1:0] idx, logic [TopW-1:0] top,
			logic [TagW-1:0] t);
		if (idx >= top || t[2:0] == 3'b111) begin
			return '0;
		end
		return t[TagW-1:3];
	endfunction

	logic [TopW-1:0] ws;
	assign ws = wsize(raddr, top_q, rdata);

	// state and data registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q <= 1'b1;
			top_q <= TopW'(1);
			freed_q <= '0;
		end else begin
			state_q <= state_d;
			init_q <= 1'b0;
			top_q <= top_d;
			freed_q <= freed_d;
		end
	end

	always_ff @(posedge clk) begin
		need_q <= need_d;
		h_q <= h_d;
		n_q <= n_d;
		size_q <= size_d;
		tot_q <= tot_d;
		second_q <= second_d;
		addr_q <= addr_d;
		res_q <= res_d;
	end

	assign in_stall = (state_q != S_IDLE) || init_q;
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;

	// sequencer
	always_comb begin
		logic [16:0] fsum;
		state_d = state_q;
		top_d = top_q;
		freed_d = freed_q;
		need_d = need_q;
		h_d = h_q;
		n_d = n_q;
		size_d = size_q;
		tot_d = tot_q;
		second_d = second_q;
		addr_d = addr_q;
		res_d = res_q;
		we = init_q;
		waddr = '0;
		wdata = TagEnd;
		raddr = h_q;
		add_a = {1'b0, h_q};
		add_b = {1'b0, size_q};
		fsum = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !init_q) begin
					res_d = '{result_address: '0, status: StDone};
					addr_d = in_data.block_address;
					need_d = TopW'({1'b0, in_data.request_bytes} + 16'd7 >> 3) + TopW'(2);
					h_d = '0;
					second_d = 1'b0;
					if (in_data.action == ActFree) begin
						if (in_data.block_address == '0
								|| {1'b0, in_data.block_address} >= top_q) begin
							res_d.status = StIgnored;
							state_d = S_OUT;
						end else begin
							state_d = S_FREE_RD;
						end
					end else if (in_data.request_bytes == '0) begin
						res_d.status = StIgnored;
						state_d = S_OUT;
					end else begin
						state_d = S_FIT_RD;
					end
				end
			end
			S_FREE_RD: begin
				raddr = {1'b0, addr_q} - TopW'(1);
				state_d = S_FREE_WAIT;
			end
			S_FREE_WAIT: begin
				raddr = {1'b0, addr_q} - TopW'(1);
				size_d = rdata[TagW-1:3];
				fsum = {1'b0, freed_q} + 17'(rdata[TagW-1:3]);
				freed_d = fsum[16] ? FreedMax : fsum[15:0];
				we = 1'b1;
				waddr = raddr;
				wdata = {rdata[TagW-1:3], 3'b000};
				state_d = (rdata[TagW-1:3] != '0) ? S_FREE_WR : S_OUT;
			end
			S_FREE_WR: begin
				add_a = {2'b0, addr_q};
				add_b = {1'b0, size_q} - (TopW+1)'(2);
				we = 1'b1;
				waddr = add_y[TopW-1:0];
				wdata = {size_q, 3'b000};
				state_d = S_OUT;
			end
			// first-fit walk: issue read, then check
			S_FIT_RD: state_d = S_FIT_WAIT;
			S_FIT_WAIT: state_d = S_FIT_CHK;
			S_FIT_CHK: begin
				size_d = ws;
				if (ws == '0) begin
					if (!second_q && freed_q >= {3'b0, need_q}) begin
						second_d = 1'b1;
						h_d = '0;
						state_d = S_MRG_RD;
					end else if (!second_q) begin
						second_d = 1'b1;
						h_d = '0;
						state_d = S_FIT_RD;
					end else begin
						add_a = {1'b0, top_q};
						add_b = {1'b0, need_q};
						if (add_y > (TopW+1)'(HeapWords)) begin
							res_d.status = StNoHeap;
							state_d = S_OUT;
						end else begin
							state_d = S_EXT_WR1;
						end
					end
				end else if (!rdata[0] && ws >= need_q) begin
					state_d = S_PL_WR1;
				end else begin
					add_b = {1'b0, ws};
					h_d = add_y[TopW-1:0];
					state_d = S_FIT_RD;
				end
			end
			// merge pass
			S_MRG_RD: state_d = S_MRG_WAIT;
			S_MRG_WAIT: state_d = S_MRG_CHK;
			S_MRG_CHK: begin
				size_d = ws;
				tot_d = ws;
				add_b = {1'b0, ws};
				n_d = add_y[TopW-1:0];
				if (ws == '0) begin
					h_d = '0;
					state_d = S_FIT_RD;
				end else if (!rdata[0]) begin
					state_d = S_MRG_NRD;
				end else begin
					h_d = add_y[TopW-1:0];
					state_d = S_MRG_RD;
				end
			end
			S_MRG_NRD: begin
				raddr = n_q;
				state_d = S_MRG_NWAIT;
			end
			S_MRG_NWAIT: begin
				raddr = n_q;
				state_d = S_MRG_NCHK;
			end
			S_MRG_NCHK: begin
				raddr = n_q;
				if (ws != '0 && !rdata[0]) begin
					add_a = {1'b0, tot_q};
					add_b = {1'b0, ws};
					tot_d = add_y[TopW-1:0];
					n_d = n_q + ws;
					state_d = S_MRG_NRD;
				end else begin
					state_d = S_MRG_WR1;
				end
			end
			S_MRG_WR1: begin
				we = 1'b1;
				waddr = h_q;
				wdata = {tot_q, 3'b000};
				state_d = S_MRG_WR2;
			end
			S_MRG_WR2: begin
				add_b = {1'b0, tot_q} - (TopW+1)'(1);
				we = 1'b1;
				waddr = add_y[TopW-1:0];
				wdata = {tot_q, 3'b000};
				h_d = n_q;
				state_d = S_MRG_RD;
			end
			// place: split when more than two words remain
			S_PL_WR1: begin
				res_d.result_address = AddrW'(h_q + TopW'(1));
				we = 1'b1;
				waddr = h_q;
				if (size_q - need_q > TopW'(2)) begin
					wdata = {need_q, 3'b001};
				end else begin
					wdata = {size_q, 3'b001};
					need_d = size_q;
				end
				state_d = S_PL_WR2;
			end
			S_PL_WR2: begin
				add_b = {1'b0, need_q} - (TopW+1)'(1);
				we = 1'b1;
				waddr = add_y[TopW-1:0];
				wdata = {need_q, 3'b001};
				state_d = (need_q != size_q) ? S_PL_WR3 : S_OUT;
			end
			S_PL_WR3: begin
				add_b = {1'b0, need_q};
				we = 1'b1;
				waddr = add_y[TopW-1:0];
				wdata = {size_q - need_q, 3'b000};
				state_d = S_PL_WR4;
			end
			S_PL_WR4: begin
				add_b = {1'b0, size_q} - (TopW+1)'(1);
				we = 1'b1;
				waddr = add_y[TopW-1:0];
				wdata = {size_q - need_q, 3'b000};
				state_d = S_OUT;
			end
			// extend heap top
			S_EXT_WR1: begin
				h_d = top_q - TopW'(1);
				res_d.result_address = AddrW'(top_q);
				we = 1'b1;
				waddr = top_q - TopW'(1);
				wdata = {need_q, 3'b001};
				state_d = S_EXT_WR2;
			end
			S_EXT_WR2: begin
				add_b = {1'b0, need_q} - (TopW+1)'(1);
				we = 1'b1;
				waddr = add_y[TopW-1:0];
				wdata = {need_q, 3'b001};
				state_d = S_EXT_WR3;
			end
			S_EXT_WR3: begin
				add_b = {1'b0, need_q};
				we = 1'b1;
				waddr = add_y[TopW-1:0];
				wdata = TagEnd;
				top_d = top_q + need_q;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// checks
	a_top_nonzero: assert property (@(posedge clk) disable iff (!arst_n) top_q != '0)
		else $error("heap top dropped to zero");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_freed_mono: assert property (@(posedge clk) disable iff (!arst_n)
		freed_q >= $past(freed_q))
		else $error("freed total decreased");
	a_top_mono: assert property (@(posedge clk) disable iff (!arst_n)
		top_q >= $past(top_q))
		else $error("heap top decreased");
endmodule

@@ design/ilff_tag_ram.sv @@
// Tag memory: one write port, one read port with registered data.
// Depends on ilff_pkg.
`timescale 1ns / 1ps
module ilff_tag_ram (
	input logic clk,
	input logic we,
	input logic [ilff_pkg::AddrW-1:0] waddr,
	input logic [ilff_pkg::TagW-1:0] wdata,
	input logic [ilff_pkg::AddrW-1:0] raddr,
	output logic [ilff_pkg::TagW-1:0] rdata
);
	import ilff_pkg::*;
	logic [TagW-1:0] mem_q [HeapWords];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
